[rtl/perm_enum_pkg.sv]
// Shared types, constants and helpers for the permutation enumerator.
// Used by perm_enum_ctrl, perm_enum_dpath and permutation_enumerator_top.
package perm_enum_pkg;

   localparam int MAX_LEN = 6;
   localparam int SLOTS   = 6;
   localparam int POS_W   = 3;
   localparam int LEN_W   = 3;
   localparam int VAL_W   = 8;
   localparam int IDX_W   = 3;
   localparam int TDATA_W = SLOTS * VAL_W;

   typedef logic [POS_W-1:0] pos_type;
   typedef logic [LEN_W-1:0] len_type;
   typedef logic [VAL_W-1:0] val_type;
   typedef logic [IDX_W-1:0] idx_type;

   // Register indexes of the configuration port
   localparam idx_type CSR_LENGTH  = 3'd0;
   localparam idx_type CSR_VALUE_A = 3'd1;
   localparam idx_type CSR_VALUE_B = 3'd2;
   localparam idx_type CSR_VALUE_C = 3'd3;
   localparam idx_type CSR_VALUE_D = 3'd4;
   localparam idx_type CSR_VALUE_E = 3'd5;
   localparam idx_type CSR_VALUE_F = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_DECIDE  = 4'b0010,
      ST_REVERSE = 4'b0100,
      ST_RESULT  = 4'b1000
   } state_type;

   typedef struct packed {
      logic accept;    // capture request
      logic decide;    // restart check, pivot search and swap
      logic reverse;   // reverse the tail behind the pivot
      logic load_rsp;  // load the output register
   } cmd_type;

   typedef struct packed {
      logic need_reverse;
   } status_type;

   // Length as used: zero acts as one, above MAX_LEN acts as MAX_LEN
   function automatic len_type eff_len(input len_type len);
      len_type n;
      n = len;
      if (n == '0) n = len_type'(1);
      if (n > len_type'(MAX_LEN)) n = len_type'(MAX_LEN);
      return n;
   endfunction

   // Position to value slot, wrapping codes past the last slot
   function automatic pos_type slot_of(input pos_type p);
      pos_type s;
      s = p;
      if (p >= pos_type'(SLOTS)) s = p - pos_type'(SLOTS);
      return s;
   endfunction

endpackage

[rtl/perm_enum_ctrl.sv]
// Sequencer for the permutation enumerator: steps one request through
// decide, reverse when needed, and result, and owns the response valid flag. Uses perm_enum_pkg.
module perm_enum_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output perm_enum_pkg::cmd_type    cmd,
   input  perm_enum_pkg::status_type status
);
   import perm_enum_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = status.need_reverse ? ST_REVERSE : ST_RESULT;
         end
         ST_REVERSE: begin
            cmd.reverse = 1'b1;
            state_in    = ST_RESULT;
         end
         ST_RESULT: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/perm_enum_dpath.sv]
// Datapath of the permutation enumerator: configuration registers, position
// sequence, next-permutation step and output register. Uses perm_enum_pkg.
module perm_enum_dpath (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  perm_enum_pkg::idx_type      csr_index,
   input  perm_enum_pkg::val_type      csr_wdata,
   input  logic                       restart,
   input  perm_enum_pkg::cmd_type      cmd,
   output perm_enum_pkg::status_type   status,
   output logic [perm_enum_pkg::TDATA_W-1:0] rsp_data,
   output logic                       rsp_last
);
   import perm_enum_pkg::*;

   len_type length_ff;
   val_type value_ff [SLOTS];
   pos_type stack_ff [SLOTS];
   pos_type stack_in [SLOTS];
   pos_type lo_ff, lo_in;
   logic    started_ff, started_in;
   logic    restart_ff;
   logic [TDATA_W-1:0] data_ff, data_in;
   logic    last_ff, last_in;

   len_type          n;
   logic [SLOTS-1:0] held, full;
   logic             load_id, found;
   pos_type          piv, swp;
   logic [POS_W:0]   src_sum;

   assign n = eff_len(length_ff);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= len_type'(1);
         for (int k = 0; k < SLOTS; k++) value_ff[k] <= '0;
      end else if (csr_we) begin
         if (csr_index == CSR_LENGTH) begin
            length_ff <= csr_wdata[LEN_W-1:0];
         end else if (csr_index >= CSR_VALUE_A && csr_index <= CSR_VALUE_F) begin
            value_ff[csr_index - CSR_VALUE_A] <= csr_wdata;
         end
      end
   end

   // decide: restart check, pivot and successor search
   always_comb begin
      held  = '0;
      full  = '0;
      found = 1'b0;
      piv   = '0;
      swp   = '0;
      for (int k = 0; k < SLOTS; k++) begin
         if (len_type'(k) < n) begin
            full[k] = 1'b1;
            if (stack_ff[k] < pos_type'(n)) held[stack_ff[k]] = 1'b1;
         end
      end
      load_id = restart_ff || !started_ff || (held != full);
      for (int k = 0; k < SLOTS - 1; k++) begin
         if (len_type'(k + 1) < n && stack_ff[k] < stack_ff[k+1]) begin
            found = 1'b1;
            piv   = pos_type'(k);
         end
      end
      for (int k = 0; k < SLOTS; k++) begin
         if (len_type'(k) < n && stack_ff[k] > stack_ff[piv]) swp = pos_type'(k);
      end
   end

   assign status.need_reverse = !load_id && found;

   always_comb begin
      stack_in   = stack_ff;
      lo_in      = lo_ff;
      started_in = started_ff;
      src_sum    = '0;
      if (cmd.decide) begin
         started_in = 1'b1;
         if (load_id || !found) begin
            for (int k = 0; k < SLOTS; k++) stack_in[k] = pos_type'(k);
         end else begin
            stack_in[piv] = stack_ff[swp];
            stack_in[swp] = stack_ff[piv];
            lo_in         = piv + pos_type'(1);
         end
      end else if (cmd.reverse) begin
         for (int k = 0; k < SLOTS; k++) begin
            if (pos_type'(k) >= lo_ff && len_type'(k) < n) begin
               src_sum     = {1'b0, lo_ff} + {1'b0, n} - (POS_W+1)'(k + 1);
               stack_in[k] = stack_ff[src_sum[POS_W-1:0]];
            end
         end
      end
   end

   // result: map positions to values, flag the fully descending order
   always_comb begin
      data_in = data_ff;
      last_in = last_ff;
      if (cmd.load_rsp) begin
         last_in = 1'b1;
         for (int k = 0; k < SLOTS; k++) begin
            if (len_type'(k) < n) data_in[k*VAL_W +: VAL_W] = value_ff[slot_of(stack_ff[k])];
            else data_in[k*VAL_W +: VAL_W] = '0;
         end
         for (int k = 0; k < SLOTS - 1; k++) begin
            if (len_type'(k + 1) < n && stack_ff[k] < stack_ff[k+1]) last_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SLOTS; k++) stack_ff[k] <= pos_type'(k);
         started_ff <= 1'b0;
      end else begin
         stack_ff   <= stack_in;
         started_ff <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) restart_ff <= restart;
      lo_ff   <= lo_in;
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_data = data_ff;
   assign rsp_last = last_ff;

endmodule

[rtl/permutation_enumerator_top.sv]
// Permutation enumerator: one request returns the next ordering of the
// configured values in lexicographic order of positions.
// A request passes through decide, reverse when the tail needs it, and result before the response is registered.
// No new request is taken until the sequencer is back in idle, and result waits for a free output register.
// A finished response may wait in the output register while the next request runs.
// Reset (synchronous, active high): length 1, values 0, identity sequence, not started.
module permutation_enumerator_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [0] restart, [7:1] zero
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [perm_enum_pkg::TDATA_W-1:0] rsp_tdata,   // out_a, out_b, ... out_f, 8 bits each
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  perm_enum_pkg::idx_type            csr_index,
   input  perm_enum_pkg::val_type            csr_wdata
);
   import perm_enum_pkg::*;

   cmd_type    cmd;
   status_type status;

   perm_enum_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   perm_enum_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .restart   (req_tdata[0]),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_tdata),
      .rsp_last  (rsp_tlast)
   );

endmodule

[dv/permutation_enumerator_top_tb.sv]
// Self-checking testbench for permutation_enumerator_top: directed and random requests,
// each response checked against an in-bench next-permutation predictor.
// Depends on perm_enum_pkg and the permutation_enumerator_top RTL.
`timescale 1ns / 1ps

module permutation_enumerator_top_tb;
   import perm_enum_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 8;

   typedef struct packed {
      logic [TDATA_W-1:0] data;
      logic               last;
   } order_rsp_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata  = '0;   // [0] restart, [7:1] zero
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [TDATA_W-1:0]  rsp_tdata;         // out_a, out_b, ... out_f, 8 bits each
   logic                rsp_tlast;
   logic                csr_we     = 1'b0;
   idx_type             csr_index  = '0;
   val_type             csr_wdata  = '0;

   // Predictor state and its copy of the registers
   pos_type             order_seq [SLOTS];
   bit                  order_started;
   len_type             cfg_length;
   val_type             cfg_value [SLOTS];

   order_rsp_type       expected_orders[$];
   order_rsp_type       oldest_order;
   int                  error_count  = 0;
   int                  stuck_cycles = 0;
   bit                  gap_en       = 1'b0;
   bit                  stall_en     = 1'b0;
   bit                  hold_rsp     = 1'b0;

   permutation_enumerator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void load_identity();
      for (int k = 0; k < SLOTS; k++) order_seq[k] = pos_type'(k);
   endfunction

   // Step to the next ordering in lexicographic order of positions, wrapping at the end
   function automatic void advance_order(input int n);
      int      i;
      int      j;
      int      lo;
      int      hi;
      pos_type t;
      i = n - 2;
      while (i >= 0 && order_seq[i] >= order_seq[i+1]) i--;
      if (i < 0) begin
         load_identity();
         return;
      end
      j = n - 1;
      while (order_seq[j] <= order_seq[i]) j--;
      t = order_seq[i];
      order_seq[i] = order_seq[j];
      order_seq[j] = t;
      lo = i + 1;
      hi = n - 1;
      while (lo < hi) begin
         t = order_seq[lo];
         order_seq[lo] = order_seq[hi];
         order_seq[hi] = t;
         lo++;
         hi--;
      end
   endfunction

   function automatic order_rsp_type next_order(input logic restart);
      int               n;
      logic [SLOTS-1:0] held;
      logic [SLOTS-1:0] full;
      order_rsp_type    r;
      n = int'(cfg_length);
      if (n < 1) n = 1;
      if (n > MAX_LEN) n = MAX_LEN;
      held = '0;
      full = '0;
      for (int k = 0; k < n; k++) begin
         full[k] = 1'b1;
         if (int'(order_seq[k]) < n) held[order_seq[k]] = 1'b1;
      end
      // Start over when asked, on the first request, or when the length no longer fits
      if (restart || !order_started || held != full) begin
         load_identity();
         order_started = 1'b1;
      end else begin
         advance_order(n);
      end
      r.data = '0;
      r.last = 1'b1;
      for (int k = 0; k < n; k++) r.data[k*VAL_W +: VAL_W] = cfg_value[order_seq[k]];
      for (int k = 0; k + 1 < n; k++)
         if (order_seq[k] < order_seq[k+1]) r.last = 1'b0;
      return r;
   endfunction

   // Track registers, predict on each request, check each response
   always @(posedge clock) begin
      if (reset) begin
         load_identity();
         order_started = 1'b0;
         cfg_length    = len_type'(1);
         for (int k = 0; k < SLOTS; k++) cfg_value[k] = '0;
         expected_orders.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_LENGTH) cfg_length = csr_wdata[LEN_W-1:0];
            else if (csr_index >= CSR_VALUE_A && csr_index <= CSR_VALUE_F)
               cfg_value[csr_index - CSR_VALUE_A] = csr_wdata;
         end
         if (req_tvalid && req_tready)
            expected_orders = {expected_orders, next_order(req_tdata[0])};
         if (rsp_tvalid && rsp_tready) begin
            if (expected_orders.size() == 0) begin
               $display("%0t: unexpected response data=%h last=%b", $time, rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               oldest_order = expected_orders.pop_front();
               for (int k = 0; k < SLOTS; k++)
                  if (rsp_tdata[k*VAL_W +: VAL_W] !== oldest_order.data[k*VAL_W +: VAL_W]) begin
                     $display("%0t: slot %0d expected %0d actual %0d", $time, k,
                              $signed(oldest_order.data[k*VAL_W +: VAL_W]),
                              $signed(rsp_tdata[k*VAL_W +: VAL_W]));
                     error_count++;
                  end
               if (rsp_tlast !== oldest_order.last) begin
                  $display("%0t: last expected %b actual %b", $time, oldest_order.last, rsp_tlast);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("permutation_enumerator_top_tb NOT OK");
            $finish;
         end
      end
   end

   // Response side: random ready bursts, stalls, and one long hold-off on request
   initial begin
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (stall_en && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
   end

   task automatic send_request(input logic restart);
      if (gap_en && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, restart};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_csr(input idx_type idx, input val_type value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input len_type len, input val_type v0, input val_type v1,
                            input val_type v2, input val_type v3, input val_type v4,
                            input val_type v5);
      write_csr(CSR_LENGTH, val_type'(len));
      write_csr(CSR_VALUE_A, v0);
      write_csr(CSR_VALUE_B, v1);
      write_csr(CSR_VALUE_C, v2);
      write_csr(CSR_VALUE_D, v3);
      write_csr(CSR_VALUE_E, v4);
      write_csr(CSR_VALUE_F, v5);
   endtask

   // Drop valid and let every outstanding response come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_orders.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_state();
      send_request(1'b0);
      send_request(1'b0);
      wait_idle();
   endtask

   task automatic test_full_cycle();
      configure(3'd3, 8'h80, 8'h7f, 8'h05, 8'h11, 8'h22, 8'h33);
      repeat (7) send_request(1'b0);
      send_request(1'b1);
      wait_idle();
   endtask

   task automatic test_length_clamp();
      configure(3'd0, 8'hff, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05);
      repeat (2) send_request(1'b0);
      wait_idle();
      configure(3'd7, 8'h80, 8'h7f, 8'h00, 8'hff, 8'h55, 8'haa);
      repeat (2) send_request(1'b0);
      wait_idle();
   endtask

   task automatic test_length_change();
      write_csr(CSR_LENGTH, 8'd4);
      repeat (4) send_request(1'b0);
      wait_idle();
      // Held sequence no longer fits two positions: expect a fresh identity
      write_csr(CSR_LENGTH, 8'd2);
      repeat (2) send_request(1'b0);
      wait_idle();
      write_csr(CSR_LENGTH, 8'd5);
      send_request(1'b0);
      wait_idle();
   endtask

   task automatic test_value_change();
      send_request(1'b0);
      wait_idle();
      write_csr(CSR_VALUE_A, 8'h7f);
      write_csr(CSR_VALUE_F, 8'h80);
      repeat (2) send_request(1'b0);
      wait_idle();
   endtask

   task automatic test_backpressure();
      gap_en   = 1'b0;
      hold_rsp = 1'b1;
      repeat (30) send_request($urandom_range(0, 9) == 0);
      wait_idle();
   endtask

   task automatic test_random_orders();
      gap_en   = 1'b1;
      stall_en = 1'b1;
      for (int phase = 0; phase < 6; phase++) begin
         configure(len_type'($urandom_range(0, 7)), val_type'($urandom_range(0, 255)),
                   val_type'($urandom_range(0, 255)), val_type'($urandom_range(0, 255)),
                   val_type'($urandom_range(0, 255)), val_type'($urandom_range(0, 255)),
                   val_type'($urandom_range(0, 255)));
         repeat (40) send_request($urandom_range(0, 19) == 0);
         wait_idle();
      end
      // Walk all 720 orderings of six values through the wrap
      configure(3'd6, val_type'($urandom_range(0, 255)), val_type'($urandom_range(0, 255)),
                val_type'($urandom_range(0, 255)), val_type'($urandom_range(0, 255)),
                val_type'($urandom_range(0, 255)), val_type'($urandom_range(0, 255)));
      for (int n = 0; n < 725; n++) begin
         if (n == 625) begin
            gap_en   = 1'b0;
            stall_en = 1'b0;
         end
         send_request(1'b0);
      end
      wait_idle();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_full_cycle();
      test_length_clamp();
      test_length_change();
      test_value_change();
      test_backpressure();
      test_random_orders();
      if (error_count == 0 && expected_orders.size() == 0) begin
         $display("permutation_enumerator_top_tb OK");
      end else begin
         $display("permutation_enumerator_top_tb NOT OK");
      end
      $finish;
   end

endmodule

[files.f]
rtl/perm_enum_pkg.sv
rtl/perm_enum_ctrl.sv
rtl/perm_enum_dpath.sv
rtl/permutation_enumerator_top.sv
dv/permutation_enumerator_top_tb.sv
